/* hdl/gtb_pkg.sv */
// ----------------------------------------------------------------------------
// gtb_pkg
// Shared types, constants and helpers of the gaussian tone burst generator.
// ----------------------------------------------------------------------------
package gtb_pkg;

  // pipeline depth, input register to output register
  localparam int NST = 14;

  localparam logic [24:0] MAX_SAMPLES = 25'd65536;

  localparam logic [30:0] Q30_ONE = 31'd1073741824;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  // sin(pi/2*z) odd polynomial, Q30
  localparam logic [30:0] COEF_A1 = 31'd1686629713;
  localparam logic [29:0] COEF_A3 = 30'd693598668;
  localparam logic [26:0] COEF_A5 = 27'd85569278;
  localparam logic [22:0] COEF_A7 = 23'd5026991;
  localparam logic [17:0] COEF_A9 = 18'd172272;

  // exp(-n) for n = 0..15, Q30
  localparam logic [30:0] EXP_NEG_INT [16] = '{
    31'd1073741824, 31'd395007547, 31'd145315159, 31'd53458457,
    31'd19666268,   31'd7234816,   31'd2661539,   31'd979126,
    31'd360199,     31'd132510,    31'd48748,     31'd17933,
    31'd6597,       31'd2427,      31'd893,       31'd328
  };

  // floor(2^24 / 3)
  localparam logic [22:0] DIV3_MUL = 23'd5592405;

  // register reset values
  localparam logic        RST_WAVE_SELECT = 1'b0;
  localparam logic [31:0] RST_START_PHASE = 32'd0;
  localparam logic [31:0] RST_PHASE_STEP  = 32'd21474836;
  localparam logic [15:0] RST_BURST_LAST  = 16'd30;
  localparam logic        RST_ENV_ON      = 1'b0;
  localparam logic [23:0] RST_ENV_CENTER  = 24'd3840;
  localparam logic [23:0] RST_ENV_RATE    = 24'd65536;

  typedef enum logic [2:0] {
    REG_WAVE_SELECT = 3'd0,
    REG_START_PHASE = 3'd1,
    REG_PHASE_STEP  = 3'd2,
    REG_BURST_LAST  = 3'd3,
    REG_ENV_ON      = 3'd4,
    REG_ENV_CENTER  = 3'd5,
    REG_ENV_RATE    = 3'd6
  } gtb_reg_t;

  typedef struct packed {
    logic               wave_select;
    logic [31:0]        start_phase;
    logic [31:0]        phase_step;
    logic [15:0]        burst_last;
    logic               env_on;
    logic signed [23:0] env_center;
    logic [23:0]        env_rate;
  } gtb_cfg_t;

  typedef struct packed {
    logic [30:0] mag;
    logic        neg;
    logic        past;
  } gtb_sine_res_t;

  // floor(x / 3) for x below 2^21: reciprocal multiply, one correction step
  function automatic logic [19:0] div3(input logic [20:0] x);
    logic [44:0] p;
    logic [19:0] q;
    logic [21:0] r;
    p = 45'(x) * 45'(DIV3_MUL);
    q = p[43:24];
    r = {1'b0, x} - 22'(q) * 22'd3;
    if (r >= 22'd3) begin
      q = q + 20'd1;
    end
    return q;
  endfunction

endpackage

/* hdl/gtb_ctrl.sv */
// ----------------------------------------------------------------------------
// gtb_ctrl
// Valid bits and per-stage load enables of the sample pipeline.
// ----------------------------------------------------------------------------
module gtb_ctrl import gtb_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_ready,
  output logic           in_ready,
  output logic           out_valid,
  output logic [NST-1:0] en
);

  logic [NST-1:0] v_r;

  // a stage loads unless it and every stage after it are full and the output stalls
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = out_ready || !(&v_r[NST-1:k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NST-1];

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r && !out_ready) |-> !in_ready)
    else $error("input taken while pipeline full and stalled");

  a_en_order: assert property (@(posedge clk) disable iff (!rst_n)
    en[NST-1] |-> en[0])
    else $error("later stage advances while first stage holds");

  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NST/2] && !en[NST/2]) |=> v_r[NST/2])
    else $error("held item lost in middle stage");

  a_out_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("stalled output item dropped");

endmodule

/* hdl/gtb_sine.sv */
// ----------------------------------------------------------------------------
// gtb_sine
// Phase from sample index times step, and polynomial sine, one multiply per stage.
// ----------------------------------------------------------------------------
module gtb_sine import gtb_pkg::*; (
  input  logic           clk,
  input  logic [NST-1:0] en,
  input  gtb_cfg_t       cfg,
  input  logic [15:0]    sample_index,
  output gtb_sine_res_t  res
);

  logic [31:0] pm_r;
  logic [11:0] past_r;
  logic [11:1] neg_r;
  logic [30:0] z_r    [1:6];
  logic [30:0] zsq_r  [2:5];
  logic [22:0] t7_r;
  logic [26:0] t5_r;
  logic [29:0] t3_r;
  logic [30:0] t1_r;
  logic [30:0] mag_r  [7:11];

  logic [47:0] pm_prod;
  logic        past_nxt;
  logic [31:0] phase;
  logic [30:0] z_low;
  logic [30:0] z_nxt;
  logic [61:0] zsq_prod;
  logic [48:0] t7_prod;
  logic [61:0] t5_prod;
  logic [61:0] t3_prod;
  logic [61:0] t1_prod;
  logic [61:0] mag_prod;

  always_comb begin
    pm_prod  = 48'(sample_index) * 48'(cfg.phase_step);
    past_nxt = (sample_index > cfg.burst_last) || ({9'd0, sample_index} >= MAX_SAMPLES);
    phase    = cfg.start_phase + pm_r + (cfg.wave_select ? QUARTER_TURN : 32'd0);
    z_low    = {1'b0, phase[29:0]};
    z_nxt    = phase[30] ? (Q30_ONE - z_low) : z_low;
    zsq_prod = 62'(z_r[1]) * 62'(z_r[1]);
    t7_prod  = 49'(zsq_r[2]) * 49'(COEF_A9);
    t5_prod  = 62'(zsq_r[3]) * 62'(t7_r);
    t3_prod  = 62'(zsq_r[4]) * 62'(t5_r);
    t1_prod  = 62'(zsq_r[5]) * 62'(t3_r);
    mag_prod = 62'(z_r[6]) * 62'(t1_r);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pm_r      <= pm_prod[31:0];
      past_r[0] <= past_nxt;
    end
    for (int k = 1; k < 12; k++) begin
      if (en[k]) begin
        past_r[k] <= past_r[k-1];
      end
    end
    if (en[1]) begin
      z_r[1]   <= z_nxt;
      neg_r[1] <= phase[31];
    end
    for (int k = 2; k < 12; k++) begin
      if (en[k]) begin
        neg_r[k] <= neg_r[k-1];
      end
    end
    for (int k = 2; k <= 6; k++) begin
      if (en[k]) begin
        z_r[k] <= z_r[k-1];
      end
    end
    if (en[2]) begin
      zsq_r[2] <= zsq_prod[60:30];
    end
    for (int k = 3; k <= 5; k++) begin
      if (en[k]) begin
        zsq_r[k] <= zsq_r[k-1];
      end
    end
    if (en[3]) begin
      t7_r <= COEF_A7 - 23'(t7_prod >> 30);
    end
    if (en[4]) begin
      t5_r <= COEF_A5 - 27'(t5_prod >> 30);
    end
    if (en[5]) begin
      t3_r <= COEF_A3 - 30'(t3_prod >> 30);
    end
    if (en[6]) begin
      t1_r <= COEF_A1 - 31'(t1_prod >> 30);
    end
    if (en[7]) begin
      mag_r[7] <= 31'(mag_prod >> 30);
    end
    for (int k = 8; k <= 11; k++) begin
      if (en[k]) begin
        mag_r[k] <= mag_r[k-1];
      end
    end
  end

  assign res.mag  = mag_r[11];
  assign res.neg  = neg_r[11];
  assign res.past = past_r[11];

endmodule

/* hdl/gtb_env.sv */
// ----------------------------------------------------------------------------
// gtb_env
// Gaussian envelope: distance scaling, square, series for exp and squarings.
// ----------------------------------------------------------------------------
module gtb_env import gtb_pkg::*; (
  input  logic           clk,
  input  logic [NST-1:0] en,
  input  gtb_cfg_t       cfg,
  input  logic [15:0]    sample_index,
  output logic [30:0]    env
);

  logic [24:0] ad_r;
  logic [18:0] xq_r;
  logic        big_r;
  logic [15:0] f_r;
  logic [3:0]  n_r   [2:10];
  logic        ez_r  [2:10];
  logic [26:0] h_r   [3:6];
  logic [23:0] h2_r  [3:6];
  logic [20:0] h3_r  [4:5];
  logic [17:0] h4_r;
  logic [19:0] h6_r;
  logic [19:0] h24_r;
  logic [30:0] g_r   [7:10];
  logic [30:0] env_r;

  logic signed [25:0] d;
  logic [25:0]        d_neg;
  logic [24:0]        ad_nxt;
  logic [48:0]        xq_prod;
  logic [37:0]        u_prod;
  logic [20:0]        u;
  logic [26:0]        h_nxt;
  logic [53:0]        h2_prod;
  logic [50:0]        h3_prod;
  logic [47:0]        h4_prod;
  logic [31:0]        g_sum;
  logic [61:0]        gsq_prod [8:10];
  logic [61:0]        env_prod;

  always_comb begin
    d       = $signed({2'b00, sample_index, 8'd0}) - 26'(cfg.env_center);
    d_neg   = 26'd0 - d;
    ad_nxt  = d[25] ? d_neg[24:0] : d[24:0];
    xq_prod = 49'(ad_r) * 49'(cfg.env_rate);
    u_prod  = 38'(xq_r) * 38'(xq_r);
    u       = u_prod[37:17];
    h_nxt   = {f_r, 11'd0};
    h2_prod = 54'(h_nxt) * 54'(h_nxt);
    h3_prod = 51'(h2_r[3]) * 51'(h_r[3]);
    h4_prod = 48'(h3_r[4]) * 48'(h_r[4]);
    g_sum   = 32'(Q30_ONE) - 32'(h_r[6]) + 32'(h2_r[6] >> 1) - 32'(h6_r) + 32'(h24_r);
    for (int k = 8; k <= 10; k++) begin
      gsq_prod[k] = 62'(g_r[k-1]) * 62'(g_r[k-1]);
    end
    env_prod = 62'(EXP_NEG_INT[n_r[10]]) * 62'(g_r[10]);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ad_r <= ad_nxt;
    end
    if (en[1]) begin
      big_r <= (xq_prod[48:8] >= 41'd393216);
      xq_r  <= xq_prod[26:8];
    end
    if (en[2]) begin
      ez_r[2] <= big_r || u[20];
      n_r[2]  <= u[19:16];
      f_r     <= u[15:0];
    end
    for (int k = 3; k <= 10; k++) begin
      if (en[k]) begin
        ez_r[k] <= ez_r[k-1];
        n_r[k]  <= n_r[k-1];
      end
    end
    if (en[3]) begin
      h_r[3]  <= h_nxt;
      h2_r[3] <= 24'(h2_prod >> 30);
    end
    for (int k = 4; k <= 6; k++) begin
      if (en[k]) begin
        h_r[k]  <= h_r[k-1];
        h2_r[k] <= h2_r[k-1];
      end
    end
    if (en[4]) begin
      h3_r[4] <= 21'(h3_prod >> 30);
    end
    if (en[5]) begin
      h3_r[5] <= h3_r[4];
      h4_r    <= 18'(h4_prod >> 30);
    end
    if (en[6]) begin
      h6_r  <= div3({1'b0, h3_r[5][20:1]});
      h24_r <= div3({6'd0, h4_r[17:3]});
    end
    if (en[7]) begin
      g_r[7] <= g_sum[30:0];
    end
    for (int k = 8; k <= 10; k++) begin
      if (en[k]) begin
        g_r[k] <= gsq_prod[k][60:30];
      end
    end
    if (en[11]) begin
      env_r <= ez_r[10] ? 31'd0 : 31'(env_prod >> 30);
    end
  end

  assign env = env_r;

endmodule

/* hdl/gtb_out.sv */
// ----------------------------------------------------------------------------
// gtb_out
// Envelope product when env_on, rounding to Q1.15, saturation, sign and burst gating.
// ----------------------------------------------------------------------------
module gtb_out import gtb_pkg::*; (
  input  logic           clk,
  input  logic [NST-1:0] en,
  input  logic           env_on,
  input  gtb_sine_res_t  sine,
  input  logic [30:0]    env,
  output logic [15:0]    amplitude
);

  logic [30:0] m_r;
  logic        neg_r;
  logic        past_r;
  logic [15:0] amp_r;

  logic [61:0] m_prod;
  logic [31:0] rnd;
  logic [15:0] sat;
  logic [15:0] amp_nxt;

  always_comb begin
    m_prod = 62'(sine.mag) * 62'(env);
    rnd    = 32'(m_r) + 32'd16384;
    sat    = (rnd[31:15] > 17'd32767) ? 16'd32767 : rnd[30:15];
    if (past_r) begin
      amp_nxt = 16'd0;
    end else if (neg_r) begin
      amp_nxt = 16'd0 - sat;
    end else begin
      amp_nxt = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-2]) begin
      m_r    <= env_on ? 31'(m_prod >> 30) : sine.mag;
      neg_r  <= sine.neg;
      past_r <= sine.past;
    end
    if (en[NST-1]) begin
      amp_r <= amp_nxt;
    end
  end

  assign amplitude = amp_r;

endmodule

/* hdl/gaussian_tone_burst_generator_unit.sv */
// ----------------------------------------------------------------------------
// gaussian_tone_burst_generator_unit
// Gaussian-windowed tone burst: one Q1.15 sample for each sample index.
//
//   port group  dir  payload                          accepted when
//   in_*        in   tdata[15:0] sample_index         in_tvalid & in_tready
//   out_*       out  tdata[15:0] amplitude (signed)   out_tvalid & out_tready
//   cfg_*       in   index 0..6, wdata 32 bits        cfg_we
//
// One item per clock unless the pipeline is full and the output stalls.
// The depth follows the chain of dependent multiplies: the sine polynomial
// and the envelope series with its three squarings, one multiply a stage.
// A stalled output holds its item; empty stages upstream still fill.
// Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module gaussian_tone_burst_generator_unit import gtb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] amplitude
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  gtb_cfg_t      cfg_r;
  logic [NST-1:0] en;
  gtb_sine_res_t sine_res;
  logic [30:0]   env;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wave_select <= RST_WAVE_SELECT;
      cfg_r.start_phase <= RST_START_PHASE;
      cfg_r.phase_step  <= RST_PHASE_STEP;
      cfg_r.burst_last  <= RST_BURST_LAST;
      cfg_r.env_on      <= RST_ENV_ON;
      cfg_r.env_center  <= RST_ENV_CENTER;
      cfg_r.env_rate    <= RST_ENV_RATE;
    end else if (cfg_we) begin
      case (gtb_reg_t'(cfg_index))
        REG_WAVE_SELECT: cfg_r.wave_select <= cfg_wdata[0];
        REG_START_PHASE: cfg_r.start_phase <= cfg_wdata;
        REG_PHASE_STEP:  cfg_r.phase_step  <= cfg_wdata;
        REG_BURST_LAST:  cfg_r.burst_last  <= cfg_wdata[15:0];
        REG_ENV_ON:      cfg_r.env_on      <= cfg_wdata[0];
        REG_ENV_CENTER:  cfg_r.env_center  <= cfg_wdata[23:0];
        REG_ENV_RATE:    cfg_r.env_rate    <= cfg_wdata[23:0];
        default: begin
        end
      endcase
    end
  end

  gtb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .out_ready (out_tready),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .en        (en)
  );

  gtb_sine u_sine (
    .clk          (clk),
    .en           (en),
    .cfg          (cfg_r),
    .sample_index (in_tdata),
    .res          (sine_res)
  );

  gtb_env u_env (
    .clk          (clk),
    .en           (en),
    .cfg          (cfg_r),
    .sample_index (in_tdata),
    .env          (env)
  );

  gtb_out u_out (
    .clk       (clk),
    .en        (en),
    .env_on    (cfg_r.env_on),
    .sine      (sine_res),
    .env       (env),
    .amplitude (out_tdata)
  );

endmodule

/* tb/tb_gaussian_tone_burst_generator_unit.sv */
// ----------------------------------------------------------------------------
// tb_gaussian_tone_burst_generator_unit
// Streams sample indexes through the tone burst generator under a series of
// register settings and checks every amplitude item against a bit-exact
// fixed-point predictor of the windowed sine or cosine, with random idling
// on both sides and one long output hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module tb_gaussian_tone_burst_generator_unit;
  import gtb_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_AT = 650;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_SETTINGS = 16;
  localparam int ITEMS_PER_SETTING = 100;

  localparam logic [63:0] Q30 = 64'd1073741824;
  localparam logic [63:0] POLY_A1 = 64'd1686629713;
  localparam logic [63:0] POLY_A3 = 64'd693598668;
  localparam logic [63:0] POLY_A5 = 64'd85569278;
  localparam logic [63:0] POLY_A7 = 64'd5026991;
  localparam logic [63:0] POLY_A9 = 64'd172272;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [31:0] cfg_wdata = 32'd0;

  gtb_cfg_t    tone_cfg;
  logic [15:0] index_backlog[$];
  logic [15:0] amp_expected[$];
  logic [15:0] amp_want;
  bit          steady = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          items_in = 0;
  int          amps_seen = 0;
  int          amps_nonzero = 0;
  int          faults = 0;
  int          settings_used = 0;
  int          cycles = 0;

  gaussian_tone_burst_generator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [15:0] sample_index
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [15:0] amplitude
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // expected amplitude of one sample index under the given registers
  function automatic logic [15:0] burst_amplitude(input gtb_cfg_t c, input logic [15:0] idx);
    logic [31:0] ph;
    logic [63:0] z, z2, t, mag, r;
    logic signed [63:0] d;
    logic [63:0] ad, xq, u, h, h2, h3, h4, g, en, env;
    logic neg;
    if (idx > c.burst_last) begin
      return 16'd0;
    end
    ph = c.start_phase + 32'(idx) * c.phase_step;
    if (c.wave_select) begin
      ph = ph + 32'h4000_0000;
    end
    // quarter-wave polynomial
    z = {34'd0, ph[29:0]};
    if (ph[30]) begin
      z = Q30 - z;
    end
    neg = ph[31];
    z2 = (z * z) >> 30;
    t = POLY_A7 - ((z2 * POLY_A9) >> 30);
    t = POLY_A5 - ((z2 * t) >> 30);
    t = POLY_A3 - ((z2 * t) >> 30);
    t = POLY_A1 - ((z2 * t) >> 30);
    mag = (z * t) >> 30;
    // gaussian window
    env = 64'd0;
    d = $signed({40'd0, idx, 8'd0} - {{40{c.env_center[23]}}, c.env_center});
    ad = d[63] ? (64'd0 - d) : d;
    xq = (ad * {40'd0, c.env_rate}) >> 8;
    if (xq < (64'd6 << 16)) begin
      u = (xq * xq) >> 17;
      if (u < (64'd16 << 16)) begin
        h = {48'd0, u[15:0]} << 11;
        h2 = (h * h) >> 30;
        h3 = (h2 * h) >> 30;
        h4 = (h3 * h) >> 30;
        g = Q30 - h + h2 / 64'd2 - h3 / 64'd6 + h4 / 64'd24;
        g = (g * g) >> 30;
        g = (g * g) >> 30;
        g = (g * g) >> 30;
        case (u[19:16])
          4'd0:    en = 64'd1073741824;
          4'd1:    en = 64'd395007547;
          4'd2:    en = 64'd145315159;
          4'd3:    en = 64'd53458457;
          4'd4:    en = 64'd19666268;
          4'd5:    en = 64'd7234816;
          4'd6:    en = 64'd2661539;
          4'd7:    en = 64'd979126;
          4'd8:    en = 64'd360199;
          4'd9:    en = 64'd132510;
          4'd10:   en = 64'd48748;
          4'd11:   en = 64'd17933;
          4'd12:   en = 64'd6597;
          4'd13:   en = 64'd2427;
          4'd14:   en = 64'd893;
          default: en = 64'd328;
        endcase
        env = (en * g) >> 30;
      end
    end
    if (c.env_on) begin
      mag = (mag * env) >> 30;
    end
    r = (mag + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    if (neg) begin
      r = (64'd65536 - r) & 64'hFFFF;
    end
    return r[15:0];
  endfunction

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_WAVE_SELECT: tone_cfg.wave_select = value[0];
      REG_START_PHASE: tone_cfg.start_phase = value;
      REG_PHASE_STEP:  tone_cfg.phase_step = value;
      REG_BURST_LAST:  tone_cfg.burst_last = value[15:0];
      REG_ENV_ON:      tone_cfg.env_on = value[0];
      REG_ENV_CENTER:  tone_cfg.env_center = value[23:0];
      REG_ENV_RATE:    tone_cfg.env_rate = value[23:0];
      default: ;
    endcase
  endtask

  task automatic close_writes;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used = settings_used + 1;
    @(negedge clk);
  endtask

  task automatic wait_idle;
    while (index_backlog.size() != 0 || in_tvalid || amp_expected.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic log_fault(input string what, input logic [15:0] want, input logic [15:0] got);
    if (faults < 10) begin
      $display("%s at amplitude item %0d: expected %0d got %0d", what, amps_seen,
               $signed(want), $signed(got));
    end
    faults = faults + 1;
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        amp_expected.push_back(burst_amplitude(tone_cfg, in_tdata));
        items_in <= items_in + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (index_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 15)) begin
          in_tvalid <= 1'b1;
          in_tdata <= index_backlog.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off once enough items are in
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_in >= HOLD_AT) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_tready <= steady || ($urandom_range(0, 99) >= 15);
    end
  end

  // checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (amp_expected.size() == 0) begin
        log_fault("unexpected amplitude", 16'd0, out_tdata);
      end else begin
        amp_want = amp_expected.pop_front();
        if (out_tdata !== amp_want) begin
          log_fault("amplitude mismatch", amp_want, out_tdata);
        end
      end
      if (out_tdata != 16'd0) begin
        amps_nonzero <= amps_nonzero + 1;
      end
      amps_seen <= amps_seen + 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout with %0d amplitudes still expected", amp_expected.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned span;
    int p, k, pick, center_int, idx;
    logic [31:0] step;
    logic [15:0] burst;
    logic [23:0] center, rate;

    tone_cfg.wave_select = RST_WAVE_SELECT;
    tone_cfg.start_phase = RST_START_PHASE;
    tone_cfg.phase_step = RST_PHASE_STEP;
    tone_cfg.burst_last = RST_BURST_LAST;
    tone_cfg.env_on = RST_ENV_ON;
    tone_cfg.env_center = RST_ENV_CENTER;
    tone_cfg.env_rate = RST_ENV_RATE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset registers: burst edge, index extremes
    settings_used = 1;
    index_backlog = '{16'd0, 16'd1, 16'd30, 16'd31, 16'd32768, 16'hFFFF};
    wait_idle();

    // cosine on quarter turns, plus a write to an unmapped index
    set_reg(REG_WAVE_SELECT, 32'd1);
    set_reg(REG_PHASE_STEP, 32'h4000_0000);
    set_reg(REG_BURST_LAST, 32'h0000_FFFF);
    set_reg(REG_UNUSED, 32'hFFFF_FFFF);
    close_writes();
    index_backlog = '{16'd0, 16'd1, 16'd2, 16'd3};
    wait_idle();

    // envelope across its cutoff
    set_reg(REG_WAVE_SELECT, 32'd0);
    set_reg(REG_PHASE_STEP, 32'd21474836);
    set_reg(REG_ENV_ON, 32'd1);
    close_writes();
    index_backlog = '{16'd15, 16'd17, 16'd20, 16'd21};
    wait_idle();

    // register extremes, envelope underflow
    set_reg(REG_START_PHASE, 32'hFFFF_FFFF);
    set_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
    set_reg(REG_ENV_CENTER, 32'h0080_0000);
    set_reg(REG_ENV_RATE, 32'h00FF_FFFF);
    close_writes();
    index_backlog = '{16'd0, 16'hFFFF};
    wait_idle();

    // flat envelope at the sine peak: saturation
    set_reg(REG_START_PHASE, 32'h4000_0000);
    set_reg(REG_PHASE_STEP, 32'd0);
    set_reg(REG_ENV_CENTER, 32'h007F_FFFF);
    set_reg(REG_ENV_RATE, 32'd0);
    close_writes();
    index_backlog = '{16'd5, 16'hFFFF};
    wait_idle();

    // single-sample burst
    set_reg(REG_BURST_LAST, 32'd0);
    close_writes();
    index_backlog = '{16'd0, 16'd1};
    wait_idle();

    for (p = 0; p < RANDOM_SETTINGS; p++) begin
      pick = $urandom_range(0, 9);
      step = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF :
             (pick < 6) ? $urandom_range(0, 32'h0400_0000) : $urandom;
      pick = $urandom_range(0, 9);
      burst = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
              (pick < 5) ? 16'($urandom_range(0, 255)) : 16'($urandom);
      pick = $urandom_range(0, 9);
      center = (pick == 0) ? 24'h80_0000 : (pick == 1) ? 24'h7F_FFFF :
               (pick < 4) ? 24'($urandom) :
               {1'b0, 15'($urandom_range(0, (burst < 16'd32767) ? burst : 32767)),
                8'($urandom)};
      pick = $urandom_range(0, 9);
      rate = (pick == 0) ? 24'd0 : (pick == 1) ? 24'hFF_FFFF :
             24'($urandom) >> $urandom_range(0, 23);
      set_reg(REG_WAVE_SELECT, $urandom);
      set_reg(REG_START_PHASE, $urandom);
      set_reg(REG_PHASE_STEP, step);
      set_reg(REG_BURST_LAST, {16'($urandom), burst});
      set_reg(REG_ENV_ON, {31'($urandom), 1'($urandom_range(0, 9) < 7)});
      set_reg(REG_ENV_CENTER, {8'($urandom), center});
      set_reg(REG_ENV_RATE, {8'($urandom), rate});
      close_writes();
      steady = (p == 10);

      span = (rate == 24'd0) ? 65535 : (6 * 65536) / rate + 2;
      if (span > 65535) begin
        span = 65535;
      end
      center_int = $signed(center) >>> 8;
      for (k = 0; k < ITEMS_PER_SETTING; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          idx = center_int + int'($urandom_range(0, 2 * span)) - int'(span);
          if (idx > int'(burst)) begin
            idx = burst;
          end
          if (idx < 0) begin
            idx = 0;
          end
        end else if (pick < 8) begin
          idx = $urandom_range(0, burst);
        end else begin
          idx = $urandom_range(0, 65535);
        end
        index_backlog.push_back(16'(idx));
      end
      wait_idle();
    end
    steady = 1'b0;

    repeat (NST + 6) @(posedge clk);
    $display("%0d sample indexes under %0d register settings, %0d amplitudes compared",
             items_in, settings_used, amps_seen);
    $display("%0d amplitudes nonzero, output held off %0d cycles once", amps_nonzero,
             HOLD_CYCLES);
    if (faults == 0 && amp_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d amplitudes missing", faults, amp_expected.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
